// ===== sv/merge_sort_engine_core_macros.svh =====
// ----------------------------------------------------------------------------
// merge sort engine assertion macros
// implication checks on the rising clock edge, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef MERGE_SORT_ENGINE_CORE_MACROS_SVH
`define MERGE_SORT_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define MSE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mse check failed: same-cycle implication");

// next-cycle implication
`define MSE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mse check failed: next-cycle implication");

`endif

// ===== sv/mse_pkg.sv =====
// ----------------------------------------------------------------------------
// merge sort engine package
// shared widths and default sizes
// ----------------------------------------------------------------------------
`default_nettype none

package mse_pkg;

    localparam int DATA_W    = 32;
    localparam int DEPTH_DEF = 64;

endpackage

`default_nettype wire

// ===== sv/mse_ram.sv =====
// ----------------------------------------------------------------------------
// merge sort engine generic ram
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mse_ram #(
    parameter int WIDTH = mse_pkg::DATA_W,
    parameter int DEPTH = mse_pkg::DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/merge_sort_engine_core.sv =====
// ----------------------------------------------------------------------------
// merge sort engine core
// collects a run of signed values, sorts it with stable bottom-up merge passes
// between two ping-pong rams, then streams the sorted run out
// ----------------------------------------------------------------------------
// load: one item per cycle; busy stays low until the item flagged last
// sort: ceil(log2 n) passes; a segment reads its left then right head, then each
//   S_MRG write is followed by a refill read, as each ram has one read port
// output: one result per cycle in sorted order, busy falls as the last strobe
//   ends; the receiver cannot stall
// reset: synchronous, clears the element count, dropped flag and sequencer
// ----------------------------------------------------------------------------
`default_nettype none
`include "merge_sort_engine_core_macros.svh"

module merge_sort_engine_core #(
    parameter int DEPTH = mse_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [mse_pkg::DATA_W-1:0] i_value,
    input  wire logic                              i_last,
    output logic                                   o_valid,
    output logic signed [mse_pkg::DATA_W-1:0]      o_sorted_value,
    output logic                                   o_final_res,
    output logic                                   o_overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 2;
    localparam int DW = mse_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEG,
        S_HEAD_L,
        S_FILL_L,
        S_FILL_R,
        S_MRG,
        S_OUT,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_drop, n_drop;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_width, n_width;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic signed [DW-1:0] r_lval, n_lval;
    logic signed [DW-1:0] r_rval, n_rval;
    logic          r_src, n_src;
    logic          r_vld, n_vld;
    logic          r_last, n_last;
    logic          r_ovf, n_ovf;

    logic          we_a, we_b;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [CW-1:0] raddr;
    logic [DW-1:0] rdata_a, rdata_b;
    logic signed [DW-1:0] rdata;

    logic [SW-1:0] sum_mid, sum_hi, width_x2;
    logic          l_ok, r_ok, take_l;

    mse_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr[AW-1:0]),
        .o_rdata (rdata_a)
    );

    mse_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr[AW-1:0]),
        .o_rdata (rdata_b)
    );

    assign rdata = r_src ? $signed(rdata_b) : $signed(rdata_a);

    assign sum_mid  = {2'b00, r_lo} + {2'b00, r_width};
    assign width_x2 = {1'b0, r_width, 1'b0};
    assign sum_hi   = {2'b00, r_lo} + width_x2;

    assign l_ok   = (r_i < r_mid);
    assign r_ok   = (r_j < r_hi);
    assign take_l = l_ok && (!r_ok || (r_lval <= r_rval));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_drop  = r_drop;
        n_n     = r_n;
        n_width = r_width;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_lval  = r_lval;
        n_rval  = r_rval;
        n_src   = r_src;
        n_vld   = 1'b0;
        n_last  = r_last;
        n_ovf   = r_ovf;
        we_a    = 1'b0;
        we_b    = 1'b0;
        waddr   = r_k[AW-1:0];
        wdata   = r_lval;
        raddr   = r_i;

        case (r_state)
            S_IDLE: begin
                waddr = r_count[AW-1:0];
                wdata = i_value;
                if (start) begin
                    if (r_count < CW'(DEPTH)) begin
                        we_a    = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last) begin
                        n_n     = (r_count < CW'(DEPTH)) ? r_count + CW'(1) : r_count;
                        n_ovf   = (r_count < CW'(DEPTH)) ? r_drop : 1'b1;
                        n_count = '0;
                        n_drop  = 1'b0;
                        n_src   = 1'b0;
                        n_width = CW'(1);
                        n_lo    = '0;
                        n_k     = '0;
                        n_state = (r_count == '0) ? S_OUT : S_SEG;
                    end
                end
            end
            S_SEG: begin
                if (r_lo >= r_n) begin
                    n_src = ~r_src;
                    n_lo  = '0;
                    if (width_x2 >= {2'b00, r_n}) begin
                        n_k     = '0;
                        n_state = S_OUT;
                    end else begin
                        n_width = width_x2[CW-1:0];
                    end
                end else begin
                    n_mid   = (sum_mid >= {2'b00, r_n}) ? r_n : sum_mid[CW-1:0];
                    n_hi    = (sum_hi >= {2'b00, r_n}) ? r_n : sum_hi[CW-1:0];
                    n_i     = r_lo;
                    n_j     = (sum_mid >= {2'b00, r_n}) ? r_n : sum_mid[CW-1:0];
                    n_k     = r_lo;
                    raddr   = r_lo;
                    n_state = S_HEAD_L;
                end
            end
            S_HEAD_L: begin
                n_lval  = rdata;
                raddr   = r_j;
                n_state = S_FILL_R;
            end
            S_FILL_L: begin
                n_lval  = rdata;
                n_state = S_MRG;
            end
            S_FILL_R: begin
                n_rval  = rdata;
                n_state = S_MRG;
            end
            S_MRG: begin
                if (r_k == r_hi) begin
                    n_lo    = r_hi;
                    n_state = S_SEG;
                end else begin
                    wdata = take_l ? r_lval : r_rval;
                    we_a  = r_src;
                    we_b  = ~r_src;
                    n_k   = r_k + CW'(1);
                    if (take_l) begin
                        n_i     = r_i + CW'(1);
                        raddr   = r_i + CW'(1);
                        n_state = S_FILL_L;
                    end else begin
                        n_j     = r_j + CW'(1);
                        raddr   = r_j + CW'(1);
                        n_state = S_FILL_R;
                    end
                end
            end
            S_OUT: begin
                raddr  = r_k;
                n_vld  = 1'b1;
                n_last = (r_k + CW'(1) == r_n);
                n_k    = r_k + CW'(1);
                if (r_k + CW'(1) == r_n) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_drop  <= 1'b0;
            r_src   <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_drop  <= n_drop;
            r_src   <= n_src;
            r_vld   <= n_vld;
            r_n     <= n_n;
            r_width <= n_width;
            r_lo    <= n_lo;
            r_mid   <= n_mid;
            r_hi    <= n_hi;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_lval  <= n_lval;
            r_rval  <= n_rval;
            r_last  <= n_last;
            r_ovf   <= n_ovf;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_vld;
    assign o_sorted_value = rdata;
    assign o_final_res    = r_vld & r_last;
    assign o_overflow     = r_ovf;

    `MSE_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
    `MSE_ASSERT_IMP(a_final_valid, i_clk, i_rst_n, o_final_res, o_valid)
    `MSE_ASSERT_IMP(a_merge_bounds, i_clk, i_rst_n, r_state == S_MRG, (r_i <= r_mid) && (r_j <= r_hi) && (r_k <= r_hi))
    `MSE_ASSERT_NXT(a_close_busy, i_clk, i_rst_n, start && !busy && i_last, busy)
    `MSE_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))

endmodule

`default_nettype wire

// ===== tb/sv/merge_sort_engine_core_test.sv =====
// ----------------------------------------------------------------------------
// merge sort engine core testbench
// feeds runs of signed values through the start/busy command port, keeps its
// own copy of the element store, predicts each sorted run (with the overflow
// flag for dropped elements) and checks every strobed result against it
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module merge_sort_engine_core_test;

    localparam int STORE_DEPTH = mse_pkg::DEPTH_DEF;
    localparam int W           = mse_pkg::DATA_W;
    localparam int RANDOM_ITEMS = 40;

    typedef struct packed {
        logic signed [W-1:0] value;
        logic                final_flag;
        logic                overflow;
    } t_sorted_word;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic signed [W-1:0] i_value = '0;
    logic                i_last  = 1'b0;
    logic                busy;
    logic                o_valid;
    logic signed [W-1:0] o_sorted_value;
    logic                o_final_res;
    logic                o_overflow;

    logic signed [W-1:0] held_values[$];
    logic                held_dropped = 1'b0;
    t_sorted_word        pending_sorted[$];
    t_sorted_word        oldest_word;
    int                  error_count = 0;

    merge_sort_engine_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .o_sorted_value (o_sorted_value),
        .o_final_res    (o_final_res),
        .o_overflow     (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // store the element, and on the closing item sort the run (stable, ascending)
    function automatic void absorb_item(input logic signed [W-1:0] v, input logic l);
        logic signed [W-1:0] ordered[$];
        logic signed [W-1:0] key;
        int                  j;
        t_sorted_word        word;
        if (held_values.size() < STORE_DEPTH) begin
            held_values.push_back(v);
        end else begin
            held_dropped = 1'b1;
        end
        if (l) begin
            ordered = held_values;
            for (int i = 1; i < ordered.size(); i++) begin
                key = ordered[i];
                j = i - 1;
                while (j >= 0 && ordered[j] > key) begin
                    ordered[j + 1] = ordered[j];
                    j--;
                end
                ordered[j + 1] = key;
            end
            for (int k = 0; k < ordered.size(); k++) begin
                word.value      = ordered[k];
                word.final_flag = (k == ordered.size() - 1);
                word.overflow   = held_dropped;
                pending_sorted.push_back(word);
            end
            held_values.delete();
            held_dropped = 1'b0;
        end
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65) begin
            return 0;
        end else if (roll < 93) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    function automatic logic signed [W-1:0] pick_value(input int style);
        case (style)
            0: begin
                return $urandom;
            end
            1: begin
                return $signed($urandom_range(7)) - 4;
            end
            default: begin
                case ($urandom_range(5))
                    0: return {1'b1, {(W-1){1'b0}}};
                    1: return {1'b0, {(W-1){1'b1}}};
                    2: return '0;
                    3: return '1;
                    4: return 1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // one transfer on the command port, with a random idle gap ahead of it
    task automatic send_item(input logic signed [W-1:0] v, input logic l);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start   <= 1'b0;
            i_value <= $urandom;
            i_last  <= 1'($urandom_range(1));
            repeat (gap) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_value <= v;
        i_last  <= l;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        absorb_item(v, l);
    endtask

    task automatic send_run(input int len, input int style);
        for (int k = 0; k < len; k++) begin
            send_item(pick_value(style), k == len - 1);
        end
    endtask

    task automatic test_edge_runs();
        logic signed [W-1:0] mixed[7];
        mixed = '{{1'b0, {(W-1){1'b1}}}, {1'b1, {(W-1){1'b0}}}, 0, -1, 1,
                  {1'b1, {(W-1){1'b0}}}, {1'b0, {(W-1){1'b1}}}};
        send_item({1'b1, {(W-1){1'b0}}}, 1'b1);
        send_item({1'b0, {(W-1){1'b1}}}, 1'b1);
        foreach (mixed[k]) send_item(mixed[k], k == 6);
        send_item(-5, 1'b0);
        send_item(-5, 1'b1);
        for (int k = 0; k < 4; k++) send_item(k * 3 - 4, k == 3);
        for (int k = 0; k < 4; k++) send_item(100 - k * 7, k == 3);
    endtask

    task automatic test_full_store();
        send_run(STORE_DEPTH, 0);
    endtask

    // last flag on the first dropped element, then on a later dropped one
    task automatic test_overflow_runs();
        send_run(STORE_DEPTH + 1, 0);
        send_run(STORE_DEPTH + 5, 2);
        send_run(3, 1);
    endtask

    task automatic test_random_runs();
        int sent;
        int len;
        int roll;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                len = $urandom_range(16, 1);
            end else if (roll < 92) begin
                len = $urandom_range(STORE_DEPTH, 17);
            end else begin
                len = $urandom_range(STORE_DEPTH + 8, STORE_DEPTH + 1);
            end
            send_run(len, $urandom_range(2));
            sent += len;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_sorted.size() == 0) begin
                $error("unexpected result transfer: sorted_value %0d", o_sorted_value);
                error_count++;
            end else begin
                oldest_word = pending_sorted.pop_front();
                if (o_sorted_value !== oldest_word.value) begin
                    $error("sorted_value: expected %0d, actual %0d",
                           oldest_word.value, o_sorted_value);
                    error_count++;
                end
                if (o_final_res !== oldest_word.final_flag) begin
                    $error("final_res: expected %0b, actual %0b",
                           oldest_word.final_flag, o_final_res);
                    error_count++;
                end
                if (o_overflow !== oldest_word.overflow) begin
                    $error("overflow: expected %0b, actual %0b",
                           oldest_word.overflow, o_overflow);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_edge_runs();
        test_full_store();
        test_overflow_runs();
        test_random_runs();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_sorted.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_sorted.size() == 0) begin
            $display("merge_sort_engine_core_test: done, clean");
        end else begin
            $display("merge_sort_engine_core_test: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("merge_sort_engine_core_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
